// File: rtl/core/assert_macros.svh
// Assertion macros for the RTL files; deblock_line_filter uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Check on every clock edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// File: rtl/core/dlf_pkg.sv
// Types, widths and arithmetic helpers of the deblocking line filter.
package dlf_pkg;

    localparam int S_TDATA_W = 88;
    localparam int M_TDATA_W = 48;

    // One line across the edge with its edge parameters
    typedef struct packed {
        logic [31:0] p_samples;
        logic [31:0] q_samples;
        logic [7:0]  alpha_thr;
        logic [4:0]  beta_thr;
        logic [2:0]  strength;
        logic [4:0]  clip_base;
        logic        is_chroma;
    } line_t;

    // Filtered samples of one line
    typedef struct packed {
        logic [7:0] p2_out;
        logic [7:0] p1_out;
        logic [7:0] p0_out;
        logic [7:0] q0_out;
        logic [7:0] q1_out;
        logic [7:0] q2_out;
        logic       applied;
    } result_t;

    // Absolute difference of two samples
    function automatic logic [7:0] abs_diff(input logic [7:0] a, input logic [7:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

    // Zero-extend a sample for unsigned tap sums
    function automatic logic [11:0] ext12(input logic [7:0] v);
        return {4'b0, v};
    endfunction

    // Sample as a signed value
    function automatic logic signed [12:0] sx(input logic [7:0] v);
        return $signed({5'b0, v});
    endfunction

    // Clip to -lim..lim
    function automatic logic signed [12:0] clip_sym(input logic signed [12:0] v,
                                                    input logic [5:0] lim);
        logic signed [12:0] lim_s;
        lim_s = $signed({7'b0, lim});
        if (v > lim_s) begin
            return lim_s;
        end else if (v < -lim_s) begin
            return -lim_s;
        end
        return v;
    endfunction

    // Saturate to the 0..255 sample range
    function automatic logic [7:0] sat8(input logic signed [12:0] v);
        if (v < 13'sd0) begin
            return 8'd0;
        end else if (v > 13'sd255) begin
            return 8'd255;
        end
        return v[7:0];
    endfunction

endpackage

// File: rtl/core/deblock_line_filter.sv
// Top level of the deblocking line filter: input register, filter, result register.
//
// Channel  Dir  Bus       Contents (lowest bits first)
// s_       in   tdata     p_samples, q_samples, alpha_thr, beta_thr, strength, clip_base
// s_       in   tuser     is_chroma
// m_       out  tdata     p2_out, p1_out, p0_out, q0_out, q1_out, q2_out
// m_       out  tuser     applied
//
// An accepted beat goes through the input register, then the result register, to
// m_; one line is taken every cycle while m_tready does not stall the result
// register. A stalled result holds the result register while an empty input register
// still takes one more beat. aresetn is synchronous and empties both registers.
`include "assert_macros.svh"

module deblock_line_filter (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // p_samples[31:0], q_samples[63:32], alpha_thr[71:64], beta_thr[76:72],
    // strength[79:77], clip_base[84:80], zero pad[87:85]
    input  logic [dlf_pkg::S_TDATA_W-1:0] s_tdata,
    // is_chroma
    input  logic                          s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // p2_out[7:0], p1_out[15:8], p0_out[23:16], q0_out[31:24],
    // q1_out[39:32], q2_out[47:40]
    output logic [dlf_pkg::M_TDATA_W-1:0] m_tdata,
    // applied
    output logic                          m_tuser
);
    import dlf_pkg::*;

    line_t   s_line;
    line_t   in_line_reg;
    logic    in_vld_reg, in_vld_next;
    result_t filt_res;
    result_t out_res_reg;
    logic    out_vld_reg, out_vld_next;
    logic    out_adv, in_adv;

    // Unpack the input beat
    assign s_line.p_samples = s_tdata[31:0];
    assign s_line.q_samples = s_tdata[63:32];
    assign s_line.alpha_thr = s_tdata[71:64];
    assign s_line.beta_thr  = s_tdata[76:72];
    assign s_line.strength  = s_tdata[79:77];
    assign s_line.clip_base = s_tdata[84:80];
    assign s_line.is_chroma = s_tuser;

    // Flow control: each register moves when the one after it frees up
    assign out_adv  = !out_vld_reg || m_tready;
    assign in_adv   = !in_vld_reg || out_adv;
    assign s_tready = in_adv;

    assign in_vld_next  = in_adv ? s_tvalid : in_vld_reg;
    assign out_vld_next = out_adv ? in_vld_reg : out_vld_reg;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else begin
            in_vld_reg <= in_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && in_adv) begin
            in_line_reg <= s_line;
        end
    end

    // Filter datapath
    dlf_filter u_filter (
        .line_in (in_line_reg),
        .res_out (filt_res)
    );

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else begin
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_adv && in_vld_reg) begin
            out_res_reg <= filt_res;
        end
    end

    // Pack the result beat
    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {out_res_reg.q2_out, out_res_reg.q1_out, out_res_reg.q0_out,
                       out_res_reg.p0_out, out_res_reg.p1_out, out_res_reg.p2_out};
    assign m_tuser  = out_res_reg.applied;

    // Checks
    `ASSERT_ALWAYS(a_reset_empties, !aresetn |=> !in_vld_reg && !out_vld_reg, "reset left data")
    `ASSERT_CLK(a_accept_loads, s_tvalid && s_tready |=> in_vld_reg, "accepted beat lost")
    `ASSERT_CLK(a_in_hold, in_vld_reg && !out_adv |=> in_vld_reg && $stable(in_line_reg), "stalled line overwritten")
    `ASSERT_CLK(a_pending_moves, in_vld_reg && out_adv |=> out_vld_reg, "filtered line dropped")

endmodule

// File: rtl/core/dlf_filter.sv
// Edge filter datapath: activity tests, strong and normal filters for one line.
module dlf_filter (
    input  dlf_pkg::line_t   line_in,
    output dlf_pkg::result_t res_out
);
    import dlf_pkg::*;

    logic [7:0] p0, p1, p2, p3, q0, q1, q2, q3;
    logic [7:0] d_pq, d_p1, d_q1, d_p2, d_q2, beta8, small_thr;
    logic       pass, strong_flt, ap, aq, small_gap;
    logic [11:0] s_chr_p0, s_chr_q0;
    logic [11:0] s_lp0, s_lp1, s_lp2, s_lq0, s_lq1, s_lq2;
    logic [5:0]  tc, tc0;
    logic signed [12:0] dlt_raw, dlt_flr, delta;
    logic [8:0]  avg_sum;
    logic [7:0]  avg;
    logic signed [12:0] p1_raw, q1_raw, p1_adj, q1_adj;

    // Unpack the line
    assign p0 = line_in.p_samples[7:0];
    assign p1 = line_in.p_samples[15:8];
    assign p2 = line_in.p_samples[23:16];
    assign p3 = line_in.p_samples[31:24];
    assign q0 = line_in.q_samples[7:0];
    assign q1 = line_in.q_samples[15:8];
    assign q2 = line_in.q_samples[23:16];
    assign q3 = line_in.q_samples[31:24];

    // Activity tests
    assign d_pq       = abs_diff(p0, q0);
    assign d_p1       = abs_diff(p1, p0);
    assign d_q1       = abs_diff(q1, q0);
    assign d_p2       = abs_diff(p2, p0);
    assign d_q2       = abs_diff(q2, q0);
    assign beta8      = {3'b0, line_in.beta_thr};
    assign pass       = (line_in.strength != 3'd0) && (d_pq < line_in.alpha_thr)
                        && (d_p1 < beta8) && (d_q1 < beta8);
    assign strong_flt = (line_in.strength >= 3'd4);
    assign ap         = (d_p2 < beta8);
    assign aq         = (d_q2 < beta8);
    assign small_thr  = {2'b0, line_in.alpha_thr[7:2]} + 8'd2;
    assign small_gap  = (d_pq < small_thr);

    // Strong filter tap sums
    assign s_chr_p0 = (ext12(p1) << 1) + ext12(p0) + ext12(q1) + 12'd2;
    assign s_chr_q0 = (ext12(q1) << 1) + ext12(q0) + ext12(p1) + 12'd2;
    assign s_lp0 = ext12(p2) + (ext12(p1) << 1) + (ext12(p0) << 1) + (ext12(q0) << 1)
                   + ext12(q1) + 12'd4;
    assign s_lp1 = ext12(p2) + ext12(p1) + ext12(p0) + ext12(q0) + 12'd2;
    assign s_lp2 = (ext12(p3) << 1) + ext12(p2) + (ext12(p2) << 1) + ext12(p1)
                   + ext12(p0) + ext12(q0) + 12'd4;
    assign s_lq0 = ext12(q2) + (ext12(q1) << 1) + (ext12(q0) << 1) + (ext12(p0) << 1)
                   + ext12(p1) + 12'd4;
    assign s_lq1 = ext12(q2) + ext12(q1) + ext12(q0) + ext12(p0) + 12'd2;
    assign s_lq2 = (ext12(q3) << 1) + ext12(q2) + (ext12(q2) << 1) + ext12(q1)
                   + ext12(q0) + ext12(p0) + 12'd4;

    // Normal filter: clipped delta for p0/q0
    assign tc0     = {1'b0, line_in.clip_base};
    assign tc      = line_in.is_chroma ? (tc0 + 6'd1) : (tc0 + {5'b0, ap} + {5'b0, aq});
    assign dlt_raw = ((sx(q0) - sx(p0)) <<< 2) + sx(p1) - sx(q1) + 13'sd4;
    assign dlt_flr = dlt_raw >>> 3;
    assign delta   = clip_sym(dlt_flr, tc);

    // Normal filter: p1/q1 correction toward the edge average
    assign avg_sum = {1'b0, p0} + {1'b0, q0} + 9'd1;
    assign avg     = avg_sum[8:1];
    assign p1_raw  = (sx(p2) + sx(avg) - (sx(p1) <<< 1)) >>> 1;
    assign q1_raw  = (sx(q2) + sx(avg) - (sx(q1) <<< 1)) >>> 1;
    assign p1_adj  = clip_sym(p1_raw, tc0);
    assign q1_adj  = clip_sym(q1_raw, tc0);

    // Select the filtered samples, pass through otherwise
    always_comb begin
        res_out.p2_out  = p2;
        res_out.p1_out  = p1;
        res_out.p0_out  = p0;
        res_out.q0_out  = q0;
        res_out.q1_out  = q1;
        res_out.q2_out  = q2;
        res_out.applied = 1'b0;
        if (pass) begin
            res_out.applied = 1'b1;
            if (strong_flt) begin
                if (line_in.is_chroma) begin
                    res_out.p0_out = s_chr_p0[9:2];
                    res_out.q0_out = s_chr_q0[9:2];
                end else begin
                    if (small_gap && ap) begin
                        res_out.p0_out = s_lp0[10:3];
                        res_out.p1_out = s_lp1[9:2];
                        res_out.p2_out = s_lp2[10:3];
                    end else begin
                        res_out.p0_out = s_chr_p0[9:2];
                    end
                    if (small_gap && aq) begin
                        res_out.q0_out = s_lq0[10:3];
                        res_out.q1_out = s_lq1[9:2];
                        res_out.q2_out = s_lq2[10:3];
                    end else begin
                        res_out.q0_out = s_chr_q0[9:2];
                    end
                end
            end else begin
                res_out.p0_out = sat8(sx(p0) + delta);
                res_out.q0_out = sat8(sx(q0) - delta);
                if (!line_in.is_chroma && ap) begin
                    res_out.p1_out = sat8(sx(p1) + p1_adj);
                end
                if (!line_in.is_chroma && aq) begin
                    res_out.q1_out = sat8(sx(q1) + q1_adj);
                end
            end
        end
    end

endmodule

// File: test/deblock_line_filter_test.sv
// Self-checking testbench of the deblocking line filter: directed edge cases, then random lines.
`timescale 1ns / 100ps

module deblock_line_filter_test;
    import dlf_pkg::*;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 s_tuser = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;

    // Results predicted for accepted lines, oldest first
    result_t filtered_q[$];

    bit idle_on = 1'b1;
    int ready_hold = 0;
    int err_count = 0;
    int lines_checked = 0;
    int lines_filtered = 0;
    int lines_strong = 0;

    deblock_line_filter uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // 4 ns clock
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic int mag(input int v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic int clip_to(input int lim, input int v);
        return (v < -lim) ? -lim : ((v > lim) ? lim : v);
    endfunction

    function automatic int clamp_pixel(input int v);
        return (v < 0) ? 0 : ((v > 255) ? 255 : v);
    endfunction

    // Filtered samples of one line across the edge
    function automatic result_t filter_line(input line_t ln);
        int p0, p1, p2, p3, q0, q1, q2, q3;
        int np0, np1, np2, nq0, nq1, nq2;
        int alpha, beta, bs, tc0, tc, delta, avg;
        bit small_gap, ap, aq;
        result_t r;
        p0 = ln.p_samples[7:0];
        p1 = ln.p_samples[15:8];
        p2 = ln.p_samples[23:16];
        p3 = ln.p_samples[31:24];
        q0 = ln.q_samples[7:0];
        q1 = ln.q_samples[15:8];
        q2 = ln.q_samples[23:16];
        q3 = ln.q_samples[31:24];
        alpha = ln.alpha_thr;
        beta = ln.beta_thr;
        bs = ln.strength;
        tc0 = ln.clip_base;
        np0 = p0; np1 = p1; np2 = p2;
        nq0 = q0; nq1 = q1; nq2 = q2;
        r.applied = 1'b0;
        // strengths above 4 act as 4
        if (bs > 4) bs = 4;
        if (bs != 0 && mag(p0 - q0) < alpha && mag(p1 - p0) < beta && mag(q1 - q0) < beta) begin
            r.applied = 1'b1;
            if (bs == 4) begin
                if (ln.is_chroma) begin
                    np0 = (2 * p1 + p0 + q1 + 2) >> 2;
                    nq0 = (2 * q1 + q0 + p1 + 2) >> 2;
                end else begin
                    small_gap = mag(p0 - q0) < (alpha >> 2) + 2;
                    if (small_gap && mag(p2 - p0) < beta) begin
                        np0 = (p2 + 2 * p1 + 2 * p0 + 2 * q0 + q1 + 4) >> 3;
                        np1 = (p2 + p1 + p0 + q0 + 2) >> 2;
                        np2 = (2 * p3 + 3 * p2 + p1 + p0 + q0 + 4) >> 3;
                    end else begin
                        np0 = (2 * p1 + p0 + q1 + 2) >> 2;
                    end
                    if (small_gap && mag(q2 - q0) < beta) begin
                        nq0 = (q2 + 2 * q1 + 2 * q0 + 2 * p0 + p1 + 4) >> 3;
                        nq1 = (q2 + q1 + q0 + p0 + 2) >> 2;
                        nq2 = (2 * q3 + 3 * q2 + q1 + q0 + p0 + 4) >> 3;
                    end else begin
                        nq0 = (2 * q1 + q0 + p1 + 2) >> 2;
                    end
                end
            end else begin
                // normal filter; >>> on int floors negative values
                ap = mag(p2 - p0) < beta;
                aq = mag(q2 - q0) < beta;
                tc = ln.is_chroma ? tc0 + 1 : tc0 + int'(ap) + int'(aq);
                delta = clip_to(tc, ((q0 - p0) * 4 + (p1 - q1) + 4) >>> 3);
                np0 = clamp_pixel(p0 + delta);
                nq0 = clamp_pixel(q0 - delta);
                if (!ln.is_chroma) begin
                    avg = (p0 + q0 + 1) >> 1;
                    if (ap) np1 = clamp_pixel(p1 + clip_to(tc0, (p2 + avg - 2 * p1) >>> 1));
                    if (aq) nq1 = clamp_pixel(q1 + clip_to(tc0, (q2 + avg - 2 * q1) >>> 1));
                end
            end
        end
        r.p2_out = 8'(np2);
        r.p1_out = 8'(np1);
        r.p0_out = 8'(np0);
        r.q0_out = 8'(nq0);
        r.q1_out = 8'(nq1);
        r.q2_out = 8'(nq2);
        return r;
    endfunction

    // Result-side ready with random stall bursts
    always @(posedge aclk) begin
        if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
            m_tready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            ready_hold <= $urandom_range(0, 8);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Check each result beat, then predict each accepted input beat
    always @(posedge aclk) begin : monitor
        result_t got, want;
        line_t ln;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got.p2_out = m_tdata[7:0];
                got.p1_out = m_tdata[15:8];
                got.p0_out = m_tdata[23:16];
                got.q0_out = m_tdata[31:24];
                got.q1_out = m_tdata[39:32];
                got.q2_out = m_tdata[47:40];
                got.applied = m_tuser;
                if (filtered_q.size() == 0) begin
                    err_count++;
                    if (err_count <= 10) $display("result beat with no line pending: %h %b",
                                                  m_tdata, m_tuser);
                end else begin
                    want = filtered_q.pop_front();
                    lines_checked++;
                    if (got.applied) lines_filtered++;
                    // struct compare covers every field, X included
                    if (got !== want) begin
                        err_count++;
                        if (err_count <= 10) begin
                            $display("mismatch on line %0d", lines_checked);
                            $display("  exp p2 %h p1 %h p0 %h q0 %h q1 %h q2 %h applied %b",
                                     want.p2_out, want.p1_out, want.p0_out,
                                     want.q0_out, want.q1_out, want.q2_out, want.applied);
                            $display("  got p2 %h p1 %h p0 %h q0 %h q1 %h q2 %h applied %b",
                                     got.p2_out, got.p1_out, got.p0_out,
                                     got.q0_out, got.q1_out, got.q2_out, got.applied);
                        end
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                ln.p_samples = s_tdata[31:0];
                ln.q_samples = s_tdata[63:32];
                ln.alpha_thr = s_tdata[71:64];
                ln.beta_thr = s_tdata[76:72];
                ln.strength = s_tdata[79:77];
                ln.clip_base = s_tdata[84:80];
                ln.is_chroma = s_tuser;
                want = filter_line(ln);
                if (want.applied && ln.strength >= 3'd4) lines_strong++;
                filtered_q.push_back(want);
            end
        end
    end

    // Send one line; returns at the edge where the beat is accepted
    task automatic send_line(input line_t ln);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 9);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tdata <= {3'b000, ln.clip_base, ln.strength, ln.beta_thr, ln.alpha_thr,
                    ln.q_samples, ln.p_samples};
        s_tuser <= ln.is_chroma;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic send_edge(input logic [31:0] pw, input logic [31:0] qw, input int alpha,
                             input int beta, input int bs, input int tc0, input bit chroma);
        line_t ln;
        ln.p_samples = pw;
        ln.q_samples = qw;
        ln.alpha_thr = 8'(alpha);
        ln.beta_thr = 5'(beta);
        ln.strength = 3'(bs);
        ln.clip_base = 5'(tc0);
        ln.is_chroma = chroma;
        send_line(ln);
    endtask

    // Stop sending until every pending result has come back; the first edge lets
    // the monitor record the beat accepted at the edge the sender returned on
    task automatic drain;
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (filtered_q.size() != 0) @(posedge aclk);
    endtask

    // Sample within spread of base, kept in 0..255
    function automatic int near(input int base, input int spread);
        int s;
        s = (spread < 0) ? 0 : spread;
        return clamp_pixel(base + int'($urandom_range(0, 2 * s)) - s);
    endfunction

    // Mostly lines that pass the activity tests, some raw noise
    function automatic line_t random_line();
        line_t ln;
        int alpha, beta, gap, p0, q0, p1, q1, pick;
        if ($urandom_range(0, 4) == 0) begin
            ln = {$urandom(), $urandom(), 22'($urandom())};
            return ln;
        end
        alpha = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 8) : $urandom_range(9, 255);
        beta = ($urandom_range(0, 9) == 0) ? $urandom_range(19, 31) : $urandom_range(1, 18);
        pick = $urandom_range(0, 3);
        p0 = (pick == 0) ? $urandom_range(0, 8) :
             (pick == 1) ? $urandom_range(247, 255) : $urandom_range(0, 255);
        gap = $urandom_range(0, 1) ? (alpha >> 2) + 1 : alpha - 1;
        q0 = near(p0, gap);
        p1 = near(p0, ($urandom_range(0, 7) == 0) ? beta : beta - 1);
        q1 = near(q0, ($urandom_range(0, 7) == 0) ? beta : beta - 1);
        ln.p_samples = {8'($urandom()), 8'(near(p0, beta + 2)), 8'(p1), 8'(p0)};
        ln.q_samples = {8'($urandom()), 8'(near(q0, beta + 2)), 8'(q1), 8'(q0)};
        ln.alpha_thr = 8'(alpha);
        ln.beta_thr = 5'(beta);
        pick = $urandom_range(0, 15);
        ln.strength = (pick == 0) ? 3'd0 : (pick < 8) ? 3'($urandom_range(1, 3)) :
                      (pick < 14) ? 3'd4 : 3'($urandom_range(5, 7));
        ln.clip_base = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(26, 31))
                                                    : 5'($urandom_range(0, 25));
        ln.is_chroma = 1'($urandom());
        return ln;
    endfunction

    // No filtering: zero strength, alpha zero, and each failing activity test
    task automatic test_bypass;
        send_edge(32'h50_4E_4C_4A, 32'h52_50_4E_4C, 40, 10, 0, 5, 1'b0);
        send_edge(32'h80_80_80_80, 32'h80_80_80_80, 0, 18, 4, 5, 1'b0);
        send_edge(32'h50_4E_60_4A, 32'h52_50_4E_4C, 40, 10, 2, 5, 1'b0);
        send_edge(32'h50_4E_4C_4A, 32'h52_50_30_4C, 40, 10, 4, 5, 1'b1);
        send_edge(32'h50_4E_4C_4A, 32'h72_70_6E_72, 40, 10, 3, 5, 1'b0);
    endtask

    // Strong luma: small and large gap, one side failing, saturated strengths, extremes
    task automatic test_strong_luma;
        send_edge(32'h60_62_64_66, 32'h6E_6C_6A_68, 40, 10, 4, 3, 1'b0);
        send_edge(32'h60_62_64_66, 32'h7C_7A_78_76, 40, 10, 4, 3, 1'b0);
        send_edge(32'h60_62_64_66, 32'h80_78_6A_68, 40, 10, 4, 3, 1'b0);
        send_edge(32'h60_62_64_66, 32'h6E_6C_6A_68, 40, 10, 5, 3, 1'b0);
        send_edge(32'h60_70_64_66, 32'h6E_6C_6A_68, 40, 10, 6, 3, 1'b0);
        send_edge(32'h10_62_64_66, 32'hF0_6C_6A_68, 40, 10, 7, 3, 1'b0);
        send_edge(32'h00_00_00_00, 32'h00_00_00_00, 255, 31, 4, 31, 1'b0);
        send_edge(32'hFF_FF_FF_FF, 32'hFF_FF_FF_FF, 255, 31, 4, 31, 1'b0);
    endtask

    // Strong chroma: three-tap filter of p0 and q0 only
    task automatic test_strong_chroma;
        send_edge(32'h60_62_64_66, 32'h7C_7A_78_76, 40, 10, 4, 3, 1'b1);
        send_edge(32'hFF_00_FE_F8, 32'h00_FF_F0_FF, 255, 31, 7, 0, 1'b1);
    endtask

    // Normal luma: all strengths, saturation high and low, widest thresholds
    task automatic test_normal_luma;
        send_edge(32'h60_62_64_66, 32'h6E_6C_6A_70, 40, 10, 1, 2, 1'b0);
        send_edge(32'h60_74_64_66, 32'h6E_6C_6A_70, 40, 10, 2, 4, 1'b0);
        send_edge(32'h60_62_64_66, 32'h6E_90_6A_70, 40, 10, 3, 0, 1'b0);
        send_edge(32'hFF_FE_FF_FD, 32'hE0_E8_EB_FF, 40, 31, 2, 25, 1'b0);
        send_edge(32'h00_01_00_02, 32'h20_18_14_00, 40, 31, 2, 25, 1'b0);
        send_edge(32'h20_30_40_50, 32'h90_80_6C_70, 255, 31, 3, 31, 1'b0);
    endtask

    // Normal chroma: tc is tc0 plus one, p1 and q1 untouched
    task automatic test_normal_chroma;
        send_edge(32'h60_62_64_66, 32'h6E_6C_6A_70, 40, 10, 1, 0, 1'b1);
        send_edge(32'hFF_FE_FF_FD, 32'hE0_E8_EB_FF, 40, 31, 3, 31, 1'b1);
        send_edge(32'h00_01_00_02, 32'h20_18_14_00, 40, 31, 2, 25, 1'b1);
    endtask

    task automatic test_random(input int count, input bit with_idle);
        idle_on = with_idle;
        repeat (count) send_line(random_line());
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_bypass();
        test_strong_luma();
        test_strong_chroma();
        test_normal_luma();
        test_normal_chroma();
        test_random(350, 1'b1);
        // hold off the sender until the pipeline is empty
        drain();
        test_random(150, 1'b0);
        test_random(250, 1'b1);
        test_random(150, 1'b0);

        drain();
        repeat (8) @(posedge aclk);
        $display("checked %0d lines: %0d filtered (%0d strong), %0d passed through",
                 lines_checked, lines_filtered, lines_strong, lines_checked - lines_filtered);
        $display("%0d mismatches", err_count);
        if (err_count == 0 && filtered_q.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // Run limit
    initial begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/dlf_pkg.sv
rtl/core/dlf_filter.sv
rtl/core/deblock_line_filter.sv
test/deblock_line_filter_test.sv
